// ===== design/shgt_pkg.sv =====
// Package for the sorted hash grouping table: sizes, entry layout and controller states.
`default_nettype none
package shgt_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int MAX_USERS  = 4096;

  localparam int GRP_AW = $clog2(MAX_GROUPS);   // slot address width
  localparam int CNT_W  = GRP_AW + 1;           // holds 0..MAX_GROUPS
  localparam int USR_AW = $clog2(MAX_USERS);    // member link address width

  localparam int MEMBER_W = 12;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 10;
  localparam int TOTAL_W  = 11;

  // One table entry: list head above the sign-flipped key.
  localparam int ENTRY_W = MEMBER_W + KEY_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SWAIT,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== design/shgt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module shgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/sorted_hash_grouping_table_top.sv =====
// Sorted hash grouping table: binary search, list-head push and ordered insert.
// Flow: a binary search of at most 11 probes; a hit pushes the member on the list head, a miss
//   on a full table is dropped, and any other miss moves the entries above its slot up and inserts.
// The longest path is an insert at slot 0 with 1023 keys held, plus any result stall.
// Throughput: one request at a time; the next request enters once the result is staged.
// Reset: synchronous active-low rst_n clears control, count and out_tvalid; RAMs undefined.
`default_nettype none
module sorted_hash_grouping_table_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [11:0] member_number, [43:12] key_hash, [47:44] zero
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [9:0] slot_index, [10] new_group, [22:11] previous_member,
  //            [33:23] group_total, [34] dropped, [39:35] zero
  output logic [39:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  localparam int AW = shgt_pkg::GRP_AW;
  localparam int CW = shgt_pkg::CNT_W;
  localparam int MW = shgt_pkg::MEMBER_W;
  localparam int KW = shgt_pkg::KEY_W;
  localparam int EW = shgt_pkg::ENTRY_W;

  shgt_pkg::state_t state_r, state_nxt;

  // request and search registers
  logic [MW-1:0] member_r, member_nxt;
  logic [KW-1:0] key_r, key_nxt;       // sign bit flipped: unsigned order == signed order
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] idx_r, idx_nxt;       // one above the next slot to read during the shift
  logic [CW-1:0] wa_r, wa_nxt;         // destination of the word in flight
  logic          pend_r, pend_nxt;     // a shift read is in flight
  logic [CW-1:0] cnt_r, cnt_nxt;

  // result fields
  logic [shgt_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        new_r, new_nxt;
  logic [MW-1:0]               prev_r, prev_nxt;
  logic                        drop_r, drop_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [shgt_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;

  // table RAM ports
  logic          tbl_we, tbl_re;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [EW-1:0] tbl_wdata, tbl_rdata;

  // member link RAM write port
  logic                      nm_we;
  logic [shgt_pkg::USR_AW-1:0] nm_waddr;
  logic [MW-1:0]             nm_wdata;

  logic          in_acc;
  logic          out_load;
  logic [KW-1:0] rd_key;
  logic [MW-1:0] rd_head;
  logic [CW-1:0] mid_calc;
  logic [CW:0]   lo_hi_sum;

  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == shgt_pkg::ST_DONE) && (!out_valid_r || out_tready);
  assign rd_key    = tbl_rdata[KW-1:0];
  assign rd_head   = tbl_rdata[EW-1:KW];
  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc  = lo_hi_sum[CW:1];

  assign in_tready  = (state_r == shgt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Key and head share one RAM entry.
  shgt_ram #(
    .WIDTH (EW),
    .DEPTH (shgt_pkg::MAX_GROUPS)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Member links are kept for a list walk outside this block; nothing here reads them.
  shgt_ram #(
    .WIDTH (MW),
    .DEPTH (shgt_pkg::MAX_USERS)
  ) u_link_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shgt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = shgt_pkg::ST_SRCH;
        end
      end
      shgt_pkg::ST_SRCH: begin
        if (lo_r < hi_r) begin
          state_nxt = shgt_pkg::ST_SWAIT;
        end else if (cnt_r >= CW'(shgt_pkg::MAX_GROUPS)) begin
          state_nxt = shgt_pkg::ST_DONE;
        end else begin
          state_nxt = shgt_pkg::ST_SHIFT;
        end
      end
      shgt_pkg::ST_SWAIT: begin
        if (rd_key == key_r) begin
          state_nxt = shgt_pkg::ST_DONE;
        end else begin
          state_nxt = shgt_pkg::ST_SRCH;
        end
      end
      shgt_pkg::ST_SHIFT: begin
        if (!pend_r && !(idx_r > lo_r)) begin
          state_nxt = shgt_pkg::ST_DONE;
        end
      end
      shgt_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = shgt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shgt_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and result staging.
  always_comb begin
    member_nxt    = member_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    new_nxt       = new_r;
    prev_nxt      = prev_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;
    tbl_waddr     = '0;
    tbl_wdata     = '0;
    tbl_re        = 1'b0;
    tbl_raddr     = '0;
    nm_we         = 1'b0;
    nm_waddr      = member_r[shgt_pkg::USR_AW-1:0];
    nm_wdata      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      shgt_pkg::ST_IDLE: begin
        if (in_acc) begin
          member_nxt = in_tdata[MW-1:0];
          key_nxt    = in_tdata[MW+KW-1:MW] ^ {1'b1, {(KW-1){1'b0}}};
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          new_nxt    = 1'b0;
          drop_nxt   = 1'b0;
          prev_nxt   = '0;
          slot_nxt   = '0;
        end
      end
      shgt_pkg::ST_SRCH: begin
        if (lo_r < hi_r) begin
          // probe the middle slot
          mid_nxt   = mid_calc;
          tbl_re    = 1'b1;
          tbl_raddr = mid_calc[AW-1:0];
        end else if (cnt_r >= CW'(shgt_pkg::MAX_GROUPS)) begin
          drop_nxt = 1'b1;
        end else begin
          // miss: move slots lo..count-1 up by one, top first
          idx_nxt  = cnt_r;
          pend_nxt = 1'b0;
        end
      end
      shgt_pkg::ST_SWAIT: begin
        if (rd_key == key_r) begin
          // hit: push the member on the head of the list
          slot_nxt  = mid_r[shgt_pkg::SLOT_W-1:0];
          prev_nxt  = rd_head;
          tbl_we    = 1'b1;
          tbl_waddr = mid_r[AW-1:0];
          tbl_wdata = {member_r, key_r};
          nm_we     = 1'b1;
          nm_wdata  = rd_head;
        end else if (rd_key < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      shgt_pkg::ST_SHIFT: begin
        if (pend_r) begin
          tbl_we    = 1'b1;
          tbl_waddr = wa_r[AW-1:0];
          tbl_wdata = tbl_rdata;
        end
        if (idx_r > lo_r) begin
          tbl_re    = 1'b1;
          tbl_raddr = AW'(idx_r - CW'(1));
          wa_nxt    = idx_r;
          idx_nxt   = idx_r - CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // gap is open at lo: drop the new key in
            tbl_we    = 1'b1;
            tbl_waddr = lo_r[AW-1:0];
            tbl_wdata = {member_r, key_r};
            nm_we     = 1'b1;
            nm_wdata  = '0;
            cnt_nxt   = cnt_r + CW'(1);
            slot_nxt  = lo_r[shgt_pkg::SLOT_W-1:0];
            new_nxt   = 1'b1;
          end
        end
      end
      shgt_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, drop_r, shgt_pkg::TOTAL_W'(cnt_r), prev_r, new_r, slot_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shgt_pkg::ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    member_r   <= member_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    wa_r       <= wa_nxt;
    slot_r     <= slot_nxt;
    new_r      <= new_nxt;
    prev_r     <= prev_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
  end

  // Group count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(shgt_pkg::MAX_GROUPS))
    else $error("group count exceeds table size");

  // Count only grows, and by one, and only when an insert finishes.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1)) && (state_r == shgt_pkg::ST_DONE) && new_r)
    else $error("group count changed outside an insert");

  // Shift writes always land above the insert slot.
  a_shift_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shgt_pkg::ST_SHIFT) && pend_r |-> wa_r > lo_r)
    else $error("shift write at or below insert slot");

  // An accepted request leaves idle on the next edge.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == shgt_pkg::ST_SRCH)
    else $error("accepted request did not start search");

endmodule
`default_nettype wire
